@@ hw/rtl/pru_pkg.sv @@
// Shared types and codes of the pixel replication upscaler.
`timescale 1ns / 1ps
package pru_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int PIX_W      = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_LOAD_OK   = 2'd0,
		ST_LOAD_BUSY = 2'd1,
		ST_EMIT      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic    wr;
		logic    rd;
		status_t status;
		logic    eor;
		logic    eof;
	} seq_ctrl_t;

endpackage

@@ hw/rtl/pru_seq.sv @@
// Configuration registers and raster counters of the upscaler; issues line store ops.
`timescale 1ns / 1ps
module pru_seq #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_SCALE  = 8,
	parameter int AW         = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          take,
	input  logic                          cmd,
	output pru_pkg::seq_ctrl_t            ctrl,
	output logic [AW-1:0]                 wr_addr,
	output logic [AW-1:0]                 rd_addr
);
	import pru_pkg::*;

	localparam int SW  = $clog2(MAX_SCALE + 1);
	localparam int RW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int RHW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [SW-1:0]  scale_q;
	logic [WW-1:0]  width_q;
	logic [HW-1:0]  height_q;
	logic [AW-1:0]  load_idx_q;
	logic           row_ready_q;
	logic [AW-1:0]  src_col_q;
	logic [RW-1:0]  col_rep_q;
	logic [RW-1:0]  row_rep_q;
	logic [RHW-1:0] src_row_q;

	logic [WW-1:0] load_nxt;
	logic          last_rep, last_col, last_rrep, last_row;

	// Limits are saturated into their legal ranges as they are written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SW'(1);
			width_q  <= WW'(1);
			height_q <= HW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE: begin
					if (cfg_data[3:0] == 4'd0)
						scale_q <= SW'(1);
					else if (int'(cfg_data[3:0]) > MAX_SCALE)
						scale_q <= SW'(MAX_SCALE);
					else
						scale_q <= SW'(cfg_data[3:0]);
				end
				REG_WIDTH: begin
					if (cfg_data == '0)
						width_q <= WW'(1);
					else if (int'(cfg_data) > MAX_WIDTH)
						width_q <= WW'(MAX_WIDTH);
					else
						width_q <= WW'(cfg_data);
				end
				REG_HEIGHT: begin
					if (cfg_data == '0)
						height_q <= HW'(1);
					else if (int'(cfg_data) > MAX_HEIGHT)
						height_q <= HW'(MAX_HEIGHT);
					else
						height_q <= HW'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign load_nxt  = WW'(load_idx_q) + WW'(1);
	assign last_rep  = (SW'(col_rep_q) + SW'(1)) >= scale_q;
	assign last_col  = (WW'(src_col_q) + WW'(1)) >= width_q;
	assign last_rrep = (SW'(row_rep_q) + SW'(1)) >= scale_q;
	assign last_row  = (HW'(src_row_q) + HW'(1)) >= height_q;

	assign wr_addr = load_idx_q;
	assign rd_addr = src_col_q;

	always_comb begin
		ctrl        = '0;
		ctrl.status = ST_LOAD_OK;
		if (take) begin
			if (cmd == CMD_LOAD) begin
				if (row_ready_q) begin
					ctrl.status = ST_LOAD_BUSY;
				end else begin
					ctrl.wr     = 1'b1;
					ctrl.status = ST_LOAD_OK;
				end
			end else if (!row_ready_q) begin
				ctrl.status = ST_EMPTY;
			end else begin
				ctrl.rd     = 1'b1;
				ctrl.status = ST_EMIT;
				ctrl.eor    = last_rep && last_col;
				ctrl.eof    = last_rep && last_col && last_rrep && last_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q  <= '0;
			row_ready_q <= 1'b0;
			src_col_q   <= '0;
			col_rep_q   <= '0;
			row_rep_q   <= '0;
			src_row_q   <= '0;
		end else if (ctrl.wr) begin
			if (load_nxt >= width_q) begin
				load_idx_q  <= '0;
				row_ready_q <= 1'b1;
				src_col_q   <= '0;
				col_rep_q   <= '0;
				row_rep_q   <= '0;
			end else begin
				load_idx_q <= AW'(load_nxt);
			end
		end else if (ctrl.rd) begin
			if (!last_rep) begin
				col_rep_q <= col_rep_q + RW'(1);
			end else begin
				col_rep_q <= '0;
				if (!last_col) begin
					src_col_q <= src_col_q + AW'(1);
				end else begin
					src_col_q <= '0;
					if (!last_rrep) begin
						row_rep_q <= row_rep_q + RW'(1);
					end else begin
						// release the row and step to the next source row, or back to row zero after the last
						row_rep_q   <= '0;
						row_ready_q <= 1'b0;
						src_row_q   <= last_row ? '0 : src_row_q + RHW'(1);
					end
				end
			end
		end
	end

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr && ctrl.rd))
		else $error("line store written and read by one word");

	a_rd_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd |-> (ctrl.status == ST_EMIT) && row_ready_q)
		else $error("read issued without a held row");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(row_ready_q) |-> $past(ctrl.rd && ctrl.eor))
		else $error("row released off an output row end");

	a_hold_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(row_ready_q) |-> $past(ctrl.wr) && load_idx_q == '0)
		else $error("row held without a completing load");

endmodule

@@ hw/rtl/pixel_replication_upscaler.sv @@
// Top level of the pixel replication upscaler: line store and result pipeline.
// A result word leaves on m_axis from the output register, after its input word passes stage one.
// One load or pull word per clock unless m_axis stalls; one line store write or read a cycle.
// Stage one lets a new word in while a finished result waits for m_axis_tready.
// Reset clears counters, the row-held flag and the pipeline and sets all limits to one.
// The line store is not cleared; it holds pixels only once a row has been loaded.
`timescale 1ns / 1ps
module pixel_replication_upscaler #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_SCALE  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [23:0]                    s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                           s_axis_tuser,  // cmd
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [23:0]                    m_axis_tdata,  // out_red, out_green, out_blue
	output logic [2:0]                     m_axis_tuser,  // end_of_frame, status[1:0]
	output logic                           m_axis_tlast   // end_of_row
);
	import pru_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic             take;
	seq_ctrl_t        ctrl;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_data_s1;
	logic             valid_s1;
	seq_ctrl_t        ctrl_s1;
	logic             out_free;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_data_q;
	logic [2:0]       out_user_q;
	logic             out_last_q;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign take          = s_axis_tvalid && s_axis_tready;

	pru_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_SCALE  (MAX_SCALE),
		.AW         (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.cmd       (s_axis_tuser),
		.ctrl      (ctrl),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	// Read data holds while the word waits in stage one: reads only come with a take.
	always_ff @(posedge clk) begin
		if (ctrl.wr)
			line_mem[wr_addr] <= s_axis_tdata;
		if (ctrl.rd)
			rd_data_s1 <= line_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take)
			ctrl_s1 <= ctrl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_data_q <= ctrl_s1.rd ? rd_data_s1 : '0;
			out_user_q <= {ctrl_s1.eof, ctrl_s1.status};
			out_last_q <= ctrl_s1.eor;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("word taken with both stages full");

	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tlast &&
		(status_t'(m_axis_tuser[1:0]) == ST_EMIT))
		else $error("frame end without row end");

	a_zero_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status_t'(m_axis_tuser[1:0]) != ST_EMIT) |->
		(m_axis_tdata == '0) && !m_axis_tlast)
		else $error("pixel or flag on a non-emit word");

endmodule
